>>> design/free_bit_run_allocator_core_macros.svh
// Assertion helpers shared by the allocator RTL.
// They use the clock and reset of the module that includes them.
`ifndef FREE_BIT_RUN_ALLOCATOR_CORE_MACROS_SVH
`define FREE_BIT_RUN_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define FBRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FBRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fbra_pkg.sv
package fbra_pkg;

  // Default bitmap size in bytes
  localparam int MapBytesDef = 64;

  localparam int ByteW = 8;
  localparam int OpW   = 2;
  localparam int IdxW  = 9;
  localparam int RunW  = 10;
  localparam int CfgW  = 7;

  localparam logic [CfgW-1:0] CfgReset = 7'd64;

  // Operation codes
  localparam logic [OpW-1:0] OpClear = 2'd0;
  localparam logic [OpW-1:0] OpTest  = 2'd1;
  localparam logic [OpW-1:0] OpScan  = 2'd2;
  localparam logic [OpW-1:0] OpSet   = 2'd3;

  // Result of folding one bitmap byte into the running free count
  typedef struct packed {
    logic            hit;  // run reached the wanted length in this byte
    logic [2:0]      pos;  // bit position where it was reached
    logic [RunW-1:0] run;  // free run length after the byte
  } step_t;

endpackage

>>> design/free_bit_run_allocator_core.sv
// Channel   Signals                                              Dir
// in        in_valid_i in_ready_o operation_i bit_index_i          in
//           run_length_i new_value_i
// out       out_valid_o out_ready_i found_o start_index_o         out
//           bit_state_o
// cfg       cfg_we_i cfg_wdata_i (used_bytes)                     in
//
// Test and set pass through a read step and a modify step before the result register.
// Scan reads one bitmap byte per cycle up to the used length and stops early when the
// run is found; out-of-range requests go straight to the response step.
// Clear sweeps the RAM and then responds. After reset the same sweep runs with
// in_ready_o low and no response; configuration is taken throughout.
// One word is in flight; a new word is taken while the last result waits.
module free_bit_run_allocator_core import fbra_pkg::*; #(
  parameter int MAP_BYTES = MapBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [OpW-1:0]  operation_i,
  input  logic [IdxW-1:0] bit_index_i,
  input  logic [RunW-1:0] run_length_i,
  input  logic            new_value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            found_o,
  output logic [IdxW-1:0] start_index_o,
  output logic            bit_state_o,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

`include "free_bit_run_allocator_core_macros.svh"

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(MAP_BYTES - 1);

  // Sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StClr  = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StMod  = 3'd3;
  localparam logic [2:0] StScan = 3'd4;
  localparam logic [2:0] StResp = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CfgW-1:0] used_q;
  logic [AW-1:0]   clr_q, clr_d;
  logic            clr_rsp_q, clr_rsp_d;
  logic [CfgW-1:0] issue_q, issue_d;
  logic [CfgW-1:0] pbyte_q, pbyte_d;
  logic            pend_q, pend_d;
  logic [RunW-1:0] run_q, run_d;

  logic [OpW-1:0]  op_q;
  logic [IdxW-1:0] idx_q;
  logic [RunW-1:0] want_q;
  logic            val_q;

  logic            res_found_q, res_found_d;
  logic [IdxW-1:0] res_start_q, res_start_d;
  logic            res_state_q, res_state_d;

  logic            out_valid_q, out_valid_d;
  logic            found_q;
  logic [IdxW-1:0] start_q;
  logic            bstate_q;
  logic            out_load;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [ByteW-1:0] ram_wdata, ram_rdata;

  logic [CfgW-1:0] eff_bytes;
  logic [RunW-1:0] limit;
  logic            in_accept, in_range, scan_ok;
  logic [ByteW-1:0] bit_mask;
  logic [IdxW+1:0] start_calc;
  step_t           step;

  // Used length, capped at the bitmap size
  assign eff_bytes = (32'(used_q) > MAP_BYTES) ? CfgW'(MAP_BYTES) : used_q;
  assign limit     = {eff_bytes, 3'b000};

  assign in_ready_o = (state_q == StIdle);
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_range   = ({1'b0, bit_index_i} < limit);
  assign scan_ok    = (run_length_i != '0) && (run_length_i <= limit);

  assign bit_mask   = ByteW'(1) << idx_q[2:0];
  assign start_calc = {1'b0, pbyte_q, 3'b000} + (IdxW+2)'(step.pos) + (IdxW+2)'(1)
                      - {1'b0, want_q};

  fbra_byte_step u_step (
    .data_i (ram_rdata),
    .run_i  (run_q),
    .want_i (want_q),
    .step_o (step)
  );

  fbra_ram #(
    .Width (ByteW),
    .Depth (MAP_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    clr_rsp_d   = clr_rsp_q;
    issue_d     = issue_q;
    pbyte_d     = pbyte_q;
    pend_d      = 1'b0;
    run_d       = run_q;
    res_found_d = res_found_q;
    res_start_d = res_start_q;
    res_state_d = res_state_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = AW'(idx_q[IdxW-1:3]);
    out_load    = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          res_found_d = 1'b0;
          res_start_d = '0;
          res_state_d = 1'b0;
          unique case (operation_i)
            OpClear: begin
              state_d   = StClr;
              clr_d     = '0;
              clr_rsp_d = 1'b1;
            end
            OpTest, OpSet: begin
              state_d = in_range ? StRd : StResp;
            end
            OpScan: begin
              state_d = scan_ok ? StScan : StResp;
              issue_d = '0;
              run_d   = '0;
            end
            default: state_d = StResp;
          endcase
        end
      end
      StClr: begin
        ram_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d     = clr_rsp_q ? StResp : StIdle;
          res_found_d = 1'b1;
          res_start_d = '0;
          res_state_d = 1'b0;
        end
      end
      StRd: begin
        ram_re  = 1'b1;
        state_d = StMod;
      end
      StMod: begin
        res_found_d = 1'b1;
        if (op_q == OpSet) begin
          ram_we      = 1'b1;
          ram_waddr   = AW'(idx_q[IdxW-1:3]);
          ram_wdata   = val_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
          res_state_d = val_q;
        end else begin
          res_state_d = ram_rdata[idx_q[2:0]];
        end
        state_d = StResp;
      end
      StScan: begin
        // Issue the next byte read while the previous byte is folded in
        ram_raddr = AW'(issue_q);
        if (issue_q < eff_bytes) begin
          ram_re  = 1'b1;
          issue_d = issue_q + 1'b1;
          pbyte_d = issue_q;
          pend_d  = 1'b1;
        end
        if (pend_q) begin
          run_d = step.run;
          if (step.hit) begin
            res_found_d = 1'b1;
            res_start_d = start_calc[IdxW-1:0];
            state_d     = StResp;
            pend_d      = 1'b0;
          end else if (pbyte_q == eff_bytes - 1'b1) begin
            state_d = StResp;
            pend_d  = 1'b0;
          end
        end
      end
      StResp: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers; reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClr;
      clr_q       <= '0;
      clr_rsp_q   <= 1'b0;
      issue_q     <= '0;
      pbyte_q     <= '0;
      pend_q      <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
      used_q      <= CfgReset;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_rsp_q   <= clr_rsp_d;
      issue_q     <= issue_d;
      pbyte_q     <= pbyte_d;
      pend_q      <= pend_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        used_q <= cfg_wdata_i;
      end
    end
  end

  // Captured word and result fields
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= operation_i;
      idx_q  <= bit_index_i;
      want_q <= run_length_i;
      val_q  <= new_value_i;
    end
    res_found_q <= res_found_d;
    res_start_q <= res_start_d;
    res_state_q <= res_state_d;
    if (out_load) begin
      found_q  <= res_found_q;
      start_q  <= res_start_q;
      bstate_q <= res_state_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign start_index_o = start_q;
  assign bit_state_o   = bstate_q;

  // Checks
  `FBRA_ASSERT_NXT(a_one_word, in_accept, !in_ready_o, "second word taken while busy")
  `FBRA_ASSERT_IMP(a_we_state, ram_we, (state_q == StClr) || (state_q == StMod),
                   "bitmap written outside clear or set")
  `FBRA_ASSERT_IMP(a_pend_scan, pend_q, state_q == StScan, "byte pending outside scan")
  `FBRA_ASSERT_IMP(a_out_src, $rose(out_valid_o), $past(state_q) == StResp,
                   "result shown without response step")

endmodule

>>> design/fbra_ram.sv
module fbra_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/fbra_byte_step.sv
module fbra_byte_step import fbra_pkg::*; (
  input  logic [ByteW-1:0] data_i,
  input  logic [RunW-1:0]  run_i,
  input  logic [RunW-1:0]  want_i,
  output step_t            step_o
);

  // Walk the eight bits, lowest first; the first hit sticks
  always_comb begin
    logic [RunW-1:0] run;
    logic            hit;
    logic [2:0]      pos;
    run = run_i;
    hit = 1'b0;
    pos = 3'd0;
    for (int k = 0; k < ByteW; k++) begin
      if (data_i[k]) begin
        run = '0;
      end else begin
        run = run + 1'b1;
      end
      if (!hit && (run == want_i)) begin
        hit = 1'b1;
        pos = 3'(k);
      end
    end
    step_o.hit = hit;
    step_o.pos = pos;
    step_o.run = run;
  end

endmodule

>>> tb/sv/alloc_result_checker.sv
module alloc_result_checker
  import fbra_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [OpW-1:0]  operation_i,
  input  logic [IdxW-1:0] bit_index_i,
  input  logic [RunW-1:0] run_length_i,
  input  logic            new_value_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic            found_i,
  input  logic [IdxW-1:0] start_index_i,
  input  logic            bit_state_i,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output int unsigned     mismatches_o,
  output int unsigned     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MapBits = MapBytesDef * ByteW;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] start;
    logic            state;
  } alloc_result_t;

  // Shadow copy of the bitmap and the used-length register
  logic [MapBits-1:0] usage_map;
  logic [CfgW-1:0]    used_bytes_q;
  alloc_result_t      awaited_results[$];

  // One line per mismatch, and count it
  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches_o++;
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Apply one request word to the shadow bitmap and return the result word
  function automatic alloc_result_t bitmap_apply(input logic [OpW-1:0] op,
                                                 input logic [IdxW-1:0] idx,
                                                 input logic [RunW-1:0] want,
                                                 input logic val);
    alloc_result_t res;
    int unsigned   lim;
    int unsigned   need;
    int unsigned   run;
    res  = '0;
    need = want;
    run  = 0;
    // oversized setting acts as the full map
    if (used_bytes_q > MapBytesDef) lim = MapBits;
    else lim = int'(used_bytes_q) * ByteW;
    case (op)
      OpClear: begin
        usage_map = '0;
        res.found = 1'b1;
      end
      OpTest: begin
        if (idx < lim) begin
          res.found = 1'b1;
          res.state = usage_map[idx];
        end
      end
      OpScan: begin
        // first fit: lowest start of a free run of the wanted length
        if (need != 0 && need <= lim) begin
          for (int unsigned i = 0; i < lim; i++) begin
            if (usage_map[i]) begin
              run = 0;
            end else begin
              run++;
              if (run == need) begin
                res.found = 1'b1;
                res.start = IdxW'(i + 1 - need);
                break;
              end
            end
          end
        end
      end
      OpSet: begin
        if (idx < lim) begin
          usage_map[idx] = val;
          res.found = 1'b1;
          res.state = val;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Results are matched before new requests are queued, so a stray result
  // can never pair with a word taken in the same cycle
  always @(posedge clk_i or negedge rst_ni) begin : watch
    alloc_result_t oldest;
    if (!rst_ni) begin
      usage_map    = '0;
      used_bytes_q = CfgReset;
      awaited_results.delete();
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("result word with nothing pending", found_i, 0);
        end else begin
          oldest = awaited_results.pop_front();
          if (found_i !== oldest.found)
            flag_mismatch("found", found_i, oldest.found);
          if (start_index_i !== oldest.start)
            flag_mismatch("start_index", start_index_i, oldest.start);
          if (bit_state_i !== oldest.state)
            flag_mismatch("bit_state", bit_state_i, oldest.state);
        end
      end
      if (in_valid_i && in_ready_i)
        awaited_results.push_back(bitmap_apply(operation_i, bit_index_i,
                                               run_length_i, new_value_i));
      if (cfg_we_i) used_bytes_q = cfg_wdata_i;
      pending_o = awaited_results.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fbra_pkg::*;

  localparam int unsigned PhaseWords = 135;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [OpW-1:0]  operation_i;
  logic [IdxW-1:0] bit_index_i;
  logic [RunW-1:0] run_length_i;
  logic            new_value_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic            found_o;
  logic [IdxW-1:0] start_index_o;
  logic            bit_state_o;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  int unsigned mismatches;
  int unsigned pending;

  // stimulus-side bookkeeping
  logic        quiet;       // no idling on either side
  int unsigned calm_words;  // words left to send back to back
  int unsigned limit_bits;  // bits in use under the current setting
  int unsigned sent_words;

  free_bit_run_allocator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .bit_index_i   (bit_index_i),
    .run_length_i  (run_length_i),
    .new_value_i   (new_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .start_index_o (start_index_o),
    .bit_state_o   (bit_state_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  alloc_result_checker result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .operation_i   (operation_i),
    .bit_index_i   (bit_index_i),
    .run_length_i  (run_length_i),
    .new_value_i   (new_value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_i       (found_o),
    .start_index_i (start_index_o),
    .bit_state_i   (bit_state_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: random stall bursts, with calm stretches in between
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left  = 0;
    calm_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet || calm_left > 0) begin
        out_ready_i <= 1'b1;
        if (calm_left > 0) calm_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            out_ready_i <= 1'b0;
            stall_left = $urandom_range(0, 7);
          end
          3: begin
            out_ready_i <= 1'b1;
            calm_left = $urandom_range(20, 120);
          end
          default: out_ready_i <= 1'b1;
        endcase
      end
    end
  end

  // Present one request word and hold it until taken
  task automatic send_word(input logic [OpW-1:0] op, input int unsigned idx,
                           input int unsigned run, input logic val);
    int unsigned gap;
    gap = 0;
    if (!quiet) begin
      if (calm_words > 0) calm_words--;
      else if ($urandom_range(0, 39) == 0) calm_words = $urandom_range(10, 50);
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    end
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    bit_index_i  <= IdxW'(idx);
    run_length_i <= RunW'(run);
    new_value_i  <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_words++;
  endtask

  // Drain the block, then write the used length
  task automatic write_used(input int unsigned value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CfgW'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limit_bits = (value > MapBytesDef) ? MapBytesDef * ByteW : value * ByteW;
  endtask

  // Mostly inside the used length, sometimes anywhere
  function automatic int unsigned pick_index();
    if (limit_bits > 0 && $urandom_range(0, 9) != 0)
      return $urandom_range(0, limit_bits - 1);
    return $urandom_range(0, 511);
  endfunction

  function automatic int unsigned pick_run();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1023);
      1:       return $urandom_range(limit_bits, limit_bits + 1);
      2:       return ($urandom_range(0, 3) == 0) ? 0 : 1;
      3, 4:    return $urandom_range(1, 64);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // One random request, or a burst of sets over neighboring bits
  task automatic random_request();
    int unsigned roll;
    int unsigned base;
    int unsigned span;
    logic        val;
    roll = $urandom_range(0, 99);
    val  = ($urandom_range(0, 4) < 2);
    if (roll < 3) begin
      send_word(OpClear, $urandom_range(0, 511), $urandom_range(0, 1023), val);
    end else if (roll < 20) begin
      send_word(OpTest, pick_index(), $urandom_range(0, 1023), val);
    end else if (roll < 45) begin
      send_word(OpSet, pick_index(), $urandom_range(0, 1023), val);
    end else if (roll < 55) begin
      // fill a stretch with one value to carve runs out of the map
      base = pick_index();
      span = $urandom_range(1, 24);
      for (int unsigned k = 0; k < span && base + k < 512; k++)
        send_word(OpSet, base + k, $urandom_range(0, 1023), val);
    end else begin
      send_word(OpScan, pick_index(), pick_run(), val);
    end
  endtask

  initial begin : stimulus
    int unsigned phase_used;
    int unsigned target;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = OpClear;
    bit_index_i  = '0;
    run_length_i = '0;
    new_value_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    quiet        = 1'b0;
    calm_words   = 0;
    limit_bits   = MapBytesDef * ByteW;
    sent_words   = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: full map, field extremes, every operation
    write_used(CfgReset);
    send_word(OpClear, 0, 0, 1'b0);
    send_word(OpTest, 0, 0, 1'b0);
    send_word(OpSet, 0, 0, 1'b1);
    send_word(OpSet, 511, 1023, 1'b1);
    send_word(OpTest, 0, 0, 1'b0);
    send_word(OpTest, 511, 0, 1'b0);
    send_word(OpScan, 0, 0, 1'b0);      // zero length
    send_word(OpScan, 0, 1, 1'b0);      // lowest free bit
    send_word(OpScan, 0, 510, 1'b0);    // fits exactly between used ends
    send_word(OpScan, 0, 511, 1'b0);    // one too long for the gap
    send_word(OpScan, 0, 512, 1'b0);    // whole map, not free
    send_word(OpScan, 511, 1023, 1'b1); // longer than the map
    send_word(OpSet, 0, 0, 1'b0);
    send_word(OpSet, 511, 0, 1'b0);
    send_word(OpScan, 0, 512, 1'b0);    // whole map free
    send_word(OpSet, 7, 0, 1'b1);       // pair across a byte boundary
    send_word(OpSet, 8, 0, 1'b1);
    send_word(OpScan, 0, 10, 1'b0);
    send_word(OpScan, 0, 7, 1'b0);
    send_word(OpSet, 300, 0, 1'b0);
    send_word(OpClear, 511, 1023, 1'b1);
    send_word(OpTest, 8, 0, 1'b0);

    // Random phases over several used lengths; the last one runs flat out
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0:       phase_used = 1;
        1:       phase_used = 127;
        2:       phase_used = 0;
        3:       phase_used = 9;
        4:       phase_used = 64;
        5:       phase_used = 100;
        6:       phase_used = $urandom_range(1, 64);
        7:       phase_used = $urandom_range(0, 127);
        default: phase_used = 64;
      endcase
      quiet = (ph == 8);
      write_used(phase_used);
      target = sent_words + PhaseWords;
      while (sent_words < target) random_request();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
